### rtl/core/lbmf_pkg.sv
// Shared types, constants and fixed-point helpers for the D2Q9 forced collision pipeline.
package lbmf_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 28;
   localparam int NDIR       = 9;
   localparam int DIV_STEPS  = DATA_WIDTH;
   // Input register, one stage per quotient bit and the output register.
   localparam int DIV_LAT    = DIV_STEPS + 2;

   typedef logic signed [DATA_WIDTH-1:0] q_type;
   typedef logic signed [2*DATA_WIDTH-1:0] wide_type;

   localparam q_type Q_ONE  = 32'sd268435456;
   localparam q_type Q_HALF = 32'sd134217728;
   localparam q_type Q_MAX  = 32'sh7FFFFFFF;
   localparam q_type Q_MIN  = 32'sh80000000;
   localparam q_type C_4P5  = 32'sd1207959552;
   localparam q_type C_1P5  = 32'sd402653184;
   localparam q_type W_REST = 32'sd119304647;
   localparam q_type W_AXIS = 32'sd29826162;
   localparam q_type W_DIAG = 32'sd7456540;

   localparam logic [29:0] RELAX_RESET = 30'd287709122;
   localparam q_type       BFX_RESET   = 32'sd195;
   localparam q_type       BFY_RESET   = 32'sd0;

   localparam logic [1:0] REG_RELAX = 2'd0;
   localparam logic [1:0] REG_BFX   = 2'd1;
   localparam logic [1:0] REG_BFY   = 2'd2;

   localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
   localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

   typedef struct packed {
      q_type dist_rest;
      q_type dist_east;
      q_type dist_north;
      q_type dist_west;
      q_type dist_south;
      q_type dist_ne;
      q_type dist_nw;
      q_type dist_sw;
      q_type dist_se;
      q_type cell_force_x;
      q_type cell_force_y;
   } req_type;

   typedef struct packed {
      q_type post_rest;
      q_type post_east;
      q_type post_north;
      q_type post_west;
      q_type post_south;
      q_type post_ne;
      q_type post_nw;
      q_type post_sw;
      q_type post_se;
      q_type density;
      q_type velocity_x;
      q_type velocity_y;
   } rsp_type;

   function automatic q_type sat_q(input wide_type v);
      if (v > 64'sd2147483647) begin
         return Q_MAX;
      end
      if (v < -64'sd2147483648) begin
         return Q_MIN;
      end
      return v[DATA_WIDTH-1:0];
   endfunction

   // Product rounded to nearest with ties upward; the arithmetic shift is a floor.
   function automatic q_type qmul(input q_type a, input q_type b);
      wide_type p;
      p = wide_type'(a) * wide_type'(b) + wide_type'(Q_HALF);
      return sat_q(p >>> FRAC_BITS);
   endfunction

   function automatic q_type dot_e(input int k, input q_type a, input q_type b);
      wide_type acc;
      acc = '0;
      if (DIR_X[k] == 1) begin
         acc = acc + wide_type'(a);
      end else if (DIR_X[k] == -1) begin
         acc = acc - wide_type'(a);
      end
      if (DIR_Y[k] == 1) begin
         acc = acc + wide_type'(b);
      end else if (DIR_Y[k] == -1) begin
         acc = acc - wide_type'(b);
      end
      return sat_q(acc);
   endfunction

   function automatic q_type weight(input int k);
      if (k == 0) begin
         return W_REST;
      end
      if (k < 5) begin
         return W_AXIS;
      end
      return W_DIAG;
   endfunction

endpackage

### rtl/core/lbmf_div.sv
// Pipelined restoring divider, one quotient bit per stage, truncating and saturating.
module lbmf_div
   import lbmf_pkg::*;
(
   input  logic     clock,
   input  wide_type num,
   input  q_type    den,
   output q_type    quo
);

   logic [DATA_WIDTH-1:0] rem_ff  [DIV_STEPS+1];
   logic [DATA_WIDTH-1:0] low_ff  [DIV_STEPS+1];
   logic [DATA_WIDTH-1:0] quo_ff  [DIV_STEPS+1];
   logic [DATA_WIDTH-1:0] den_ff  [DIV_STEPS+1];
   logic                  neg_ff  [DIV_STEPS+1];
   logic                  ovf_ff  [DIV_STEPS+1];
   logic                  zero_ff [DIV_STEPS+1];
   q_type                 quo_out_ff;

   logic [2*DATA_WIDTH-1:0] nabs;
   logic [DATA_WIDTH-1:0]   dabs;
   logic [DATA_WIDTH-1:0]   mag;
   q_type                   res;

   always_comb begin
      nabs = num[2*DATA_WIDTH-1] ? (~num + 64'd1) : num;
      dabs = den[DATA_WIDTH-1] ? (~den + 32'd1) : den;
   end

   // A quotient of 2^32 or more is caught up front and saturates at the end.
   always_ff @(posedge clock) begin
      rem_ff[0]  <= nabs[2*DATA_WIDTH-1:DATA_WIDTH];
      low_ff[0]  <= nabs[DATA_WIDTH-1:0];
      quo_ff[0]  <= '0;
      den_ff[0]  <= dabs;
      neg_ff[0]  <= num[2*DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
      ovf_ff[0]  <= (nabs[2*DATA_WIDTH-1:DATA_WIDTH] >= dabs);
      zero_ff[0] <= (dabs == '0);
   end

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      logic [DATA_WIDTH:0] trial;
      logic [DATA_WIDTH:0] diff;
      logic                ge;
      always_comb begin
         trial = {rem_ff[s], low_ff[s][DATA_WIDTH-1]};
         diff  = trial - {1'b0, den_ff[s]};
         ge    = (trial >= {1'b0, den_ff[s]});
      end
      always_ff @(posedge clock) begin
         rem_ff[s+1]  <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
         low_ff[s+1]  <= {low_ff[s][DATA_WIDTH-2:0], 1'b0};
         quo_ff[s+1]  <= {quo_ff[s][DATA_WIDTH-2:0], ge};
         den_ff[s+1]  <= den_ff[s];
         neg_ff[s+1]  <= neg_ff[s];
         ovf_ff[s+1]  <= ovf_ff[s];
         zero_ff[s+1] <= zero_ff[s];
      end
   end

   always_comb begin
      mag = quo_ff[DIV_STEPS];
      if (zero_ff[DIV_STEPS]) begin
         res = '0;
      end else if (neg_ff[DIV_STEPS]) begin
         if (ovf_ff[DIV_STEPS] || (mag > 32'h80000000)) begin
            res = Q_MIN;
         end else begin
            res = ~mag + 32'd1;
         end
      end else begin
         if (ovf_ff[DIV_STEPS] || (mag > 32'h7FFFFFFF)) begin
            res = Q_MAX;
         end else begin
            res = mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_out_ff <= res;
   end

   assign quo = quo_out_ff;

endmodule

### rtl/core/lbm_d2q9_forced_collision.sv
// Top level of the D2Q9 BGK collision with Guo forcing, one lattice cell per transaction.
//
// A cell is taken at each rising edge where start is high and busy is low. busy is
// never raised, so a new cell can be offered in every cycle and the block sustains
// one cell per clock.
// A taken cell passes one input stage, the divider pipeline (one quotient bit per
// stage), one velocity stage and eight multiply stages. rsp_strobe marks each
// result for exactly one cycle, in the order the cells entered; the receiver takes
// every result and cannot stall the pipeline.
// Relaxation rate and body force are set through the APB-style port at byte
// addresses 0, 4 and 8 and should be written only while no cell is in flight.
// Synchronous reset clears the pipeline valid bits and restores the register
// defaults; cells in flight at reset are dropped.
module lbm_d2q9_forced_collision
   import lbmf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int MSTG = 8;

   // Configuration registers.
   logic [29:0] relax_ff, relax_in;
   q_type       bfx_ff, bfx_in;
   q_type       bfy_ff, bfy_in;

   always_comb begin
      relax_in = relax_ff;
      bfx_in   = bfx_ff;
      bfy_in   = bfy_ff;
      if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_RELAX: relax_in = pwdata[29:0];
            REG_BFX:   bfx_in   = pwdata;
            REG_BFY:   bfy_in   = pwdata;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relax_ff <= RELAX_RESET;
         bfx_ff   <= BFX_RESET;
         bfy_ff   <= BFY_RESET;
      end else begin
         relax_ff <= relax_in;
         bfx_ff   <= bfx_in;
         bfy_ff   <= bfy_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_RELAX: prdata = {2'b00, relax_ff};
         REG_BFX:   prdata = bfx_ff;
         REG_BFY:   prdata = bfy_ff;
         default:   prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign busy   = 1'b0;

   q_type relax_q;
   q_type scale;
   always_comb begin
      relax_q = {2'b00, relax_ff};
      scale   = sat_q(wide_type'(Q_ONE) - wide_type'({1'b0, relax_ff[29:1]}));
   end

   // Input stage: moments and total force.
   q_type f_in [NDIR];
   always_comb begin
      f_in[0] = req_data.dist_rest;
      f_in[1] = req_data.dist_east;
      f_in[2] = req_data.dist_north;
      f_in[3] = req_data.dist_west;
      f_in[4] = req_data.dist_south;
      f_in[5] = req_data.dist_ne;
      f_in[6] = req_data.dist_nw;
      f_in[7] = req_data.dist_sw;
      f_in[8] = req_data.dist_se;
   end

   wide_type rho_sum, mx_sum, my_sum;
   always_comb begin
      rho_sum = '0;
      mx_sum  = '0;
      my_sum  = '0;
      for (int k = 0; k < NDIR; k++) begin
         rho_sum = rho_sum + wide_type'(f_in[k]);
         if (DIR_X[k] == 1) begin
            mx_sum = mx_sum + wide_type'(f_in[k]);
         end else if (DIR_X[k] == -1) begin
            mx_sum = mx_sum - wide_type'(f_in[k]);
         end
         if (DIR_Y[k] == 1) begin
            my_sum = my_sum + wide_type'(f_in[k]);
         end else if (DIR_Y[k] == -1) begin
            my_sum = my_sum - wide_type'(f_in[k]);
         end
      end
   end

   logic  a_v_ff;
   q_type a_f_ff [NDIR];
   q_type a_rho_ff, a_mx_ff, a_my_ff, a_fx_ff, a_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else begin
         a_v_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NDIR; k++) begin
         a_f_ff[k] <= f_in[k];
      end
      a_rho_ff <= sat_q(rho_sum);
      a_mx_ff  <= sat_q(mx_sum);
      a_my_ff  <= sat_q(my_sum);
      a_fx_ff  <= sat_q(wide_type'(req_data.cell_force_x) + wide_type'(bfx_ff));
      a_fy_ff  <= sat_q(wide_type'(req_data.cell_force_y) + wide_type'(bfy_ff));
   end

   // Four quotients share the density as divisor.
   q_type qmx, qmy, qfx, qfy;

   lbmf_div u_div_mx (
      .clock (clock),
      .num   (wide_type'(a_mx_ff) <<< FRAC_BITS),
      .den   (a_rho_ff),
      .quo   (qmx)
   );
   lbmf_div u_div_my (
      .clock (clock),
      .num   (wide_type'(a_my_ff) <<< FRAC_BITS),
      .den   (a_rho_ff),
      .quo   (qmy)
   );
   lbmf_div u_div_fx (
      .clock (clock),
      .num   (wide_type'(a_fx_ff) <<< (FRAC_BITS - 1)),
      .den   (a_rho_ff),
      .quo   (qfx)
   );
   lbmf_div u_div_fy (
      .clock (clock),
      .num   (wide_type'(a_fy_ff) <<< (FRAC_BITS - 1)),
      .den   (a_rho_ff),
      .quo   (qfy)
   );

   // Delay line matching the divider latency.
   logic [DIV_LAT-1:0] dl_v_ff;
   q_type dl_f_ff [DIV_LAT][NDIR];
   q_type dl_rho_ff [DIV_LAT];
   q_type dl_fx_ff  [DIV_LAT];
   q_type dl_fy_ff  [DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_v_ff <= '0;
      end else begin
         dl_v_ff <= {dl_v_ff[DIV_LAT-2:0], a_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      dl_f_ff[0]   <= a_f_ff;
      dl_rho_ff[0] <= a_rho_ff;
      dl_fx_ff[0]  <= a_fx_ff;
      dl_fy_ff[0]  <= a_fy_ff;
      for (int i = 1; i < DIV_LAT; i++) begin
         dl_f_ff[i]   <= dl_f_ff[i-1];
         dl_rho_ff[i] <= dl_rho_ff[i-1];
         dl_fx_ff[i]  <= dl_fx_ff[i-1];
         dl_fy_ff[i]  <= dl_fy_ff[i-1];
      end
   end

   // Velocity stage.
   logic  b_v_ff;
   q_type b_f_ff [NDIR];
   q_type b_rho_ff, b_fx_ff, b_fy_ff, b_ux_ff, b_uy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else begin
         b_v_ff <= dl_v_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      b_f_ff   <= dl_f_ff[DIV_LAT-1];
      b_rho_ff <= dl_rho_ff[DIV_LAT-1];
      b_fx_ff  <= dl_fx_ff[DIV_LAT-1];
      b_fy_ff  <= dl_fy_ff[DIV_LAT-1];
      b_ux_ff  <= sat_q(wide_type'(qmx) + wide_type'(qfx));
      b_uy_ff  <= sat_q(wide_type'(qmy) + wide_type'(qfy));
   end

   // Multiply stages; distributions, density and velocity ride alongside.
   logic [MSTG-1:0] mv_ff;
   q_type mf_ff [MSTG][NDIR];
   q_type o_rho_ff [MSTG];
   q_type o_ux_ff  [MSTG];
   q_type o_uy_ff  [MSTG];

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= '0;
      end else begin
         mv_ff <= {mv_ff[MSTG-2:0], b_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      mf_ff[0]    <= b_f_ff;
      o_rho_ff[0] <= b_rho_ff;
      o_ux_ff[0]  <= b_ux_ff;
      o_uy_ff[0]  <= b_uy_ff;
      for (int i = 1; i < MSTG; i++) begin
         mf_ff[i]    <= mf_ff[i-1];
         o_rho_ff[i] <= o_rho_ff[i-1];
         o_ux_ff[i]  <= o_ux_ff[i-1];
         o_uy_ff[i]  <= o_uy_ff[i-1];
      end
   end

   q_type m1_uxx_ff, m1_uyy_ff, m1_uxf_ff, m1_uyf_ff;
   q_type m1_eu_ff [NDIR];
   q_type m1_ef_ff [NDIR];
   q_type m1_wrho_ff [NDIR];
   q_type m2_uu_ff, m2_uf_ff;
   q_type m2_eu2_ff [NDIR];
   q_type m2_euf_ff [NDIR];
   q_type m2_p1_ff [NDIR];
   q_type m2_ef_ff [NDIR];
   q_type m2_wrho_ff [NDIR];
   q_type m3_t15_ff;
   q_type m3_t45_ff [NDIR];
   q_type m3_efd_ff [NDIR];
   q_type m3_p1_ff [NDIR];
   q_type m3_euf_ff [NDIR];
   q_type m3_wrho_ff [NDIR];
   q_type m4_poly_ff [NDIR];
   q_type m4_g0_ff [NDIR];
   q_type m4_wrho_ff [NDIR];
   q_type m5_feq_ff [NDIR];
   q_type m5_gw_ff [NDIR];
   q_type m6_dd_ff [NDIR];
   q_type m6_guo_ff [NDIR];
   q_type m7_r_ff [NDIR];
   q_type m7_guo_ff [NDIR];
   q_type m8_post_ff [NDIR];

   always_ff @(posedge clock) begin
      m1_uxx_ff <= qmul(b_ux_ff, b_ux_ff);
      m1_uyy_ff <= qmul(b_uy_ff, b_uy_ff);
      m1_uxf_ff <= qmul(b_ux_ff, b_fx_ff);
      m1_uyf_ff <= qmul(b_uy_ff, b_fy_ff);
      m2_uu_ff  <= sat_q(wide_type'(m1_uxx_ff) + wide_type'(m1_uyy_ff));
      m2_uf_ff  <= sat_q(wide_type'(m1_uxf_ff) + wide_type'(m1_uyf_ff));
      m3_t15_ff <= qmul(C_1P5, m2_uu_ff);
      for (int k = 0; k < NDIR; k++) begin
         m1_eu_ff[k]   <= dot_e(k, b_ux_ff, b_uy_ff);
         m1_ef_ff[k]   <= dot_e(k, b_fx_ff, b_fy_ff);
         m1_wrho_ff[k] <= qmul(weight(k), b_rho_ff);

         m2_eu2_ff[k]  <= qmul(m1_eu_ff[k], m1_eu_ff[k]);
         m2_euf_ff[k]  <= qmul(m1_eu_ff[k], m1_ef_ff[k]);
         m2_p1_ff[k]   <= sat_q(wide_type'(Q_ONE)
                                + wide_type'(sat_q(wide_type'(m1_eu_ff[k]) * 64'sd3)));
         m2_ef_ff[k]   <= m1_ef_ff[k];
         m2_wrho_ff[k] <= m1_wrho_ff[k];

         m3_t45_ff[k]  <= qmul(C_4P5, m2_eu2_ff[k]);
         m3_efd_ff[k]  <= sat_q(wide_type'(m2_ef_ff[k]) - wide_type'(m2_uf_ff));
         m3_p1_ff[k]   <= m2_p1_ff[k];
         m3_euf_ff[k]  <= m2_euf_ff[k];
         m3_wrho_ff[k] <= m2_wrho_ff[k];

         m4_poly_ff[k] <= sat_q(wide_type'(sat_q(wide_type'(m3_p1_ff[k])
                                + wide_type'(m3_t45_ff[k]))) - wide_type'(m3_t15_ff));
         m4_g0_ff[k]   <= sat_q(wide_type'(sat_q(wide_type'(m3_efd_ff[k]) * 64'sd3))
                                + wide_type'(sat_q(wide_type'(m3_euf_ff[k]) * 64'sd9)));
         m4_wrho_ff[k] <= m3_wrho_ff[k];

         m5_feq_ff[k]  <= qmul(m4_wrho_ff[k], m4_poly_ff[k]);
         m5_gw_ff[k]   <= qmul(weight(k), m4_g0_ff[k]);

         m6_dd_ff[k]   <= sat_q(wide_type'(m5_feq_ff[k]) - wide_type'(mf_ff[4][k]));
         m6_guo_ff[k]  <= qmul(scale, m5_gw_ff[k]);

         m7_r_ff[k]    <= qmul(relax_q, m6_dd_ff[k]);
         m7_guo_ff[k]  <= m6_guo_ff[k];

         m8_post_ff[k] <= sat_q(wide_type'(sat_q(wide_type'(mf_ff[6][k])
                                + wide_type'(m7_r_ff[k]))) + wide_type'(m7_guo_ff[k]));
      end
   end

   assign rsp_strobe = mv_ff[MSTG-1];

   always_comb begin
      rsp_data.post_rest  = m8_post_ff[0];
      rsp_data.post_east  = m8_post_ff[1];
      rsp_data.post_north = m8_post_ff[2];
      rsp_data.post_west  = m8_post_ff[3];
      rsp_data.post_south = m8_post_ff[4];
      rsp_data.post_ne    = m8_post_ff[5];
      rsp_data.post_nw    = m8_post_ff[6];
      rsp_data.post_sw    = m8_post_ff[7];
      rsp_data.post_se    = m8_post_ff[8];
      rsp_data.density    = o_rho_ff[MSTG-1];
      rsp_data.velocity_x = o_ux_ff[MSTG-1];
      rsp_data.velocity_y = o_uy_ff[MSTG-1];
   end

endmodule
